### rtl/core/greedy_track_association_unit_macros.svh
// Assertion macros for the greedy track association unit
`ifndef GREEDY_TRACK_ASSOCIATION_UNIT_MACROS_SVH
`define GREEDY_TRACK_ASSOCIATION_UNIT_MACROS_SVH

// Check a condition at every edge outside reset
`define GTA_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check an implication at every edge outside reset
`define GTA_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/gta_pkg.sv
// Types and constants for the greedy track association unit
`timescale 1ns / 1ps
`default_nettype none
package gta_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_SQ,
    ST_SRCH_CMP,
    ST_MATCH_RD,
    ST_MATCH_PREP,
    ST_DIV,
    ST_SAT,
    ST_EMA,
    ST_VSQ,
    ST_VSUM,
    ST_ROOT,
    ST_MATCH_WR,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_AGE_CP,
    ST_EMIT
  } gta_state_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] vel_x;
    logic [23:0] vel_y;
    logic [31:0] seen_ms;
    logic [7:0]  miss;
  } gta_track_t;

  localparam logic [1:0] STAT_MATCHED = 2'd0;
  localparam logic [1:0] STAT_NEW     = 2'd1;
  localparam logic [1:0] STAT_DROP    = 2'd2;
  localparam logic [1:0] STAT_CLOSED  = 2'd3;

  localparam logic [1:0] CFG_GATE = 2'd0;
  localparam logic [1:0] CFG_MOVE = 2'd1;
  localparam logic [1:0] CFG_MISS = 2'd2;

  localparam logic CMD_FRAME = 1'b1;

  localparam logic [5:0]  DIV_STEPS    = 6'd35;
  localparam logic [5:0]  ROOT_STEPS   = 6'd24;
  localparam logic [23:0] RECIP5       = 24'd13421773;
  localparam logic [7:0]  MISS_SAT     = 8'd255;

endpackage
`default_nettype wire

### rtl/core/greedy_track_association_unit.sv
// Greedy nearest-neighbour track association over a single track memory
// A detection searches every live track not yet used in this frame; a match then updates its velocity.
// Match: 35 divide steps and 24 root steps, with read, prep, saturate, EMA, square, sum and write-back states.
// End of frame: ages each live track, keeping it or removing it by moving the last live track into its slot.
// One item at a time; the next is taken from the cycle after the beat is loaded, held while out waits.
// Synchronous active-low reset empties the table, clears used marks and the ident counter.
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_track_association_unit_macros.svh"
module greedy_track_association_unit #(
  parameter int MAX_TRACKS = 16,
  localparam int CNT_W = $clog2(MAX_TRACKS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic signed [23:0]  in_center_x,
  input  logic signed [23:0]  in_center_y,
  input  logic [31:0]         in_stamp_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [31:0]         out_track_id,
  output logic signed [23:0]  out_vel_x,
  output logic signed [23:0]  out_vel_y,
  output logic [23:0]         out_speed,
  output logic                out_moving,
  output logic [CNT_W-1:0]    out_live_tracks,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import gta_pkg::*;

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  gta_state_t state_r, state_nxt;

  logic [15:0] gate_r, move_thr_r;
  logic [7:0]  miss_lim_r;

  logic [CNT_W-1:0]      total_r, idx_r;
  logic [31:0]           next_ident_r;
  logic [MAX_TRACKS-1:0] used_r;
  logic [IDX_W-1:0]      best_r;
  logic                  found_r;
  logic [49:0]           best_d2_r;
  logic [23:0]           cx_r, cy_r;
  logic [31:0]           stamp_r;
  logic [49:0]           sqx_r, sqy_r;

  logic [31:0] dt_r, remx_r, remy_r;
  logic [34:0] numx_r, numy_r;
  logic        negx_r, negy_r;
  logic [5:0]  cnt_r;
  logic [25:0] magx_r, magy_r;
  logic [23:0] vx_r, vy_r;
  logic [47:0] rad_r;
  logic [25:0] srem_r;
  logic [23:0] root_r;

  logic [1:0]  res_status_r;
  logic [31:0] res_id_r;
  logic [23:0] res_vx_r, res_vy_r, res_speed_r;
  logic        res_moving_r;

  logic             out_valid_r, out_moving_r;
  logic [1:0]       out_status_r;
  logic [31:0]      out_id_r;
  logic [23:0]      out_vx_r, out_vy_r, out_speed_r;
  logic [CNT_W-1:0] out_live_r;

  gta_track_t mem_r [MAX_TRACKS];
  gta_track_t rd_data_r, mem_wd;
  logic             rd_en, mem_we;
  logic [IDX_W-1:0] rd_addr, mem_wa, idx_c, last_c;

  logic signed [24:0] dx_c, dy_c;
  logic signed [49:0] dxx_c, dyy_c;
  logic signed [34:0] kx_c, ky_c;
  logic [49:0]        d2_c;
  logic [31:0]        dt_c;
  logic [31:0]        gate_sq_c;
  logic [23:0]        instx_c, insty_c;
  logic signed [26:0] sx_c, sy_c;
  logic [49:0]        px_c, py_c;
  logic signed [47:0] vxx_c, vyy_c;
  logic [66:0]        divx_c, divy_c;
  logic [27:0]        rsh_c, rtrial_c;
  logic [7:0]         miss_c;
  logic               in_fire, emit_go;

  function automatic logic [66:0] div_step(input logic [31:0] rem, input logic [34:0] num,
                                           input logic [31:0] d);
    logic [32:0] sh;
    logic [32:0] diff;
    sh   = {rem, num[34]};
    diff = sh - {1'b0, d};
    if (sh >= {1'b0, d}) begin
      div_step = {diff[31:0], num[33:0], 1'b1};
    end else begin
      div_step = {sh[31:0], num[33:0], 1'b0};
    end
  endfunction

  function automatic logic [23:0] sat_inst(input logic neg, input logic [34:0] q);
    if (neg) begin
      sat_inst = (q > 35'd8388608) ? 24'h800000 : 24'(-q[23:0]);
    end else begin
      sat_inst = (q > 35'd8388607) ? 24'h7FFFFF : q[23:0];
    end
  endfunction

  function automatic logic signed [26:0] ema_sum(input logic [23:0] v, input logic [23:0] i);
    logic signed [26:0] ve, ie;
    ve = $signed({{3{v[23]}}, v});
    ie = $signed({{3{i[23]}}, i});
    ema_sum = (ve * 27'sd3) + (ie * 27'sd2);
  endfunction

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign idx_c    = idx_r[IDX_W-1:0];
  assign last_c   = IDX_W'(total_r - 1'b1);

  assign dx_c  = $signed({cx_r[23], cx_r}) - $signed({rd_data_r.pos_x[23], rd_data_r.pos_x});
  assign dy_c  = $signed({cy_r[23], cy_r}) - $signed({rd_data_r.pos_y[23], rd_data_r.pos_y});
  assign dxx_c = dx_c * dx_c;
  assign dyy_c = dy_c * dy_c;
  assign kx_c  = dx_c * 35'sd1000;
  assign ky_c  = dy_c * 35'sd1000;
  assign d2_c  = sqx_r + sqy_r;
  assign dt_c  = stamp_r - rd_data_r.seen_ms;
  assign gate_sq_c = gate_r * gate_r;
  assign divx_c = div_step(remx_r, numx_r, dt_r);
  assign divy_c = div_step(remy_r, numy_r, dt_r);
  assign instx_c = sat_inst(negx_r, numx_r);
  assign insty_c = sat_inst(negy_r, numy_r);
  assign sx_c  = ema_sum(rd_data_r.vel_x, instx_c);
  assign sy_c  = ema_sum(rd_data_r.vel_y, insty_c);
  assign px_c  = magx_r * RECIP5;
  assign py_c  = magy_r * RECIP5;
  assign vxx_c = $signed(vx_r) * $signed(vx_r);
  assign vyy_c = $signed(vy_r) * $signed(vy_r);
  assign rsh_c    = {srem_r, rad_r[47:46]};
  assign rtrial_c = {2'b00, root_r, 2'b01};
  assign miss_c = (!used_r[idx_c] && rd_data_r.miss < MISS_SAT) ? rd_data_r.miss + 8'd1
                                                                 : rd_data_r.miss;

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_addr   = idx_c;
    mem_we    = 1'b0;
    mem_wa    = idx_c;
    mem_wd    = rd_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_command == CMD_FRAME) ? ST_AGE_RD : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (idx_r >= total_r) begin
          if (found_r) begin
            state_nxt = ST_MATCH_RD;
          end else begin
            state_nxt = ST_EMIT;
            if (total_r != CNT_W'(MAX_TRACKS)) begin
              mem_we = 1'b1;
              mem_wa = total_r[IDX_W-1:0];
              mem_wd = '{ident: next_ident_r, pos_x: cx_r, pos_y: cy_r, vel_x: '0,
                         vel_y: '0, seen_ms: stamp_r, miss: '0};
            end
          end
        end else if (!used_r[idx_c]) begin
          rd_en     = 1'b1;
          state_nxt = ST_SRCH_SQ;
        end
      end
      ST_SRCH_SQ:  state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: state_nxt = ST_SRCH_RD;
      ST_MATCH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = best_r;
        state_nxt = ST_MATCH_PREP;
      end
      ST_MATCH_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_STEPS - 6'd1) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT:  state_nxt = ST_EMA;
      ST_EMA:  state_nxt = ST_VSQ;
      ST_VSQ:  state_nxt = ST_VSUM;
      ST_VSUM: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (cnt_r == ROOT_STEPS - 6'd1) begin
          state_nxt = ST_MATCH_WR;
        end
      end
      ST_MATCH_WR: begin
        mem_we    = 1'b1;
        mem_wa    = best_r;
        mem_wd    = '{ident: rd_data_r.ident, pos_x: cx_r, pos_y: cy_r, vel_x: vx_r,
                     vel_y: vy_r, seen_ms: stamp_r, miss: '0};
        state_nxt = ST_EMIT;
      end
      ST_AGE_RD: begin
        if (idx_r >= total_r) begin
          state_nxt = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_AGE_CHK;
        end
      end
      ST_AGE_CHK: begin
        state_nxt = ST_AGE_RD;
        if (miss_c > miss_lim_r) begin
          if (idx_c != last_c) begin
            rd_en     = 1'b1;
            rd_addr   = last_c;
            state_nxt = ST_AGE_CP;
          end
        end else begin
          mem_we      = 1'b1;
          mem_wd.miss = miss_c;
        end
      end
      ST_AGE_CP: begin
        mem_we    = 1'b1;
        state_nxt = ST_AGE_RD;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r     <= 16'd512;
      move_thr_r <= 16'd128;
      miss_lim_r <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GATE: gate_r     <= cfg_wdata;
        CFG_MOVE: move_thr_r <= cfg_wdata;
        CFG_MISS: miss_lim_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      next_ident_r <= '0;
      used_r       <= '0;
      found_r      <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            idx_r     <= '0;
            found_r   <= 1'b0;
            best_r    <= '0;
            best_d2_r <= {18'd0, gate_sq_c};
            cx_r      <= in_center_x;
            cy_r      <= in_center_y;
            stamp_r   <= in_stamp_ms;
          end
        end
        ST_SRCH_RD: begin
          if (idx_r >= total_r) begin
            if (!found_r) begin
              res_vx_r     <= '0;
              res_vy_r     <= '0;
              res_speed_r  <= '0;
              res_moving_r <= 1'b0;
              if (total_r != CNT_W'(MAX_TRACKS)) begin
                res_status_r         <= STAT_NEW;
                res_id_r             <= next_ident_r;
                next_ident_r         <= next_ident_r + 32'd1;
                used_r[total_r[IDX_W-1:0]] <= 1'b1;
                total_r              <= total_r + 1'b1;
              end else begin
                res_status_r <= STAT_DROP;
                res_id_r     <= '0;
              end
            end
          end else if (used_r[idx_c]) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_SRCH_SQ: begin
          sqx_r <= 50'(dxx_c);
          sqy_r <= 50'(dyy_c);
        end
        ST_SRCH_CMP: begin
          if (d2_c < best_d2_r) begin
            best_d2_r <= d2_c;
            best_r    <= idx_c;
            found_r   <= 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
        ST_MATCH_PREP: begin
          negx_r <= kx_c[34];
          negy_r <= ky_c[34];
          numx_r <= kx_c[34] ? 35'(-kx_c) : 35'(kx_c);
          numy_r <= ky_c[34] ? 35'(-ky_c) : 35'(ky_c);
          dt_r   <= (dt_c == 32'd0) ? 32'd1 : dt_c;
          remx_r <= '0;
          remy_r <= '0;
          cnt_r  <= '0;
        end
        ST_DIV: begin
          {remx_r, numx_r} <= divx_c;
          {remy_r, numy_r} <= divy_c;
          cnt_r <= cnt_r + 6'd1;
        end
        ST_SAT: begin
          negx_r <= sx_c[26];
          negy_r <= sy_c[26];
          magx_r <= sx_c[26] ? 26'(-sx_c) : 26'(sx_c);
          magy_r <= sy_c[26] ? 26'(-sy_c) : 26'(sy_c);
        end
        ST_EMA: begin
          vx_r <= negx_r ? 24'(-px_c[49:26]) : px_c[49:26];
          vy_r <= negy_r ? 24'(-py_c[49:26]) : py_c[49:26];
        end
        ST_VSQ: begin
          sqx_r <= {2'b00, vxx_c};
          sqy_r <= {2'b00, vyy_c};
        end
        ST_VSUM: begin
          rad_r  <= sqx_r[47:0] + sqy_r[47:0];
          srem_r <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
        ST_ROOT: begin
          if (rsh_c >= rtrial_c) begin
            srem_r <= 26'(rsh_c - rtrial_c);
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            srem_r <= rsh_c[25:0];
            root_r <= {root_r[22:0], 1'b0};
          end
          rad_r <= {rad_r[45:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
        end
        ST_MATCH_WR: begin
          used_r[best_r] <= 1'b1;
          res_status_r   <= STAT_MATCHED;
          res_id_r       <= rd_data_r.ident;
          res_vx_r       <= vx_r;
          res_vy_r       <= vy_r;
          res_speed_r    <= root_r;
          res_moving_r   <= (root_r > {8'd0, move_thr_r});
        end
        ST_AGE_RD: begin
          if (idx_r >= total_r) begin
            used_r       <= '0;
            res_status_r <= STAT_CLOSED;
            res_id_r     <= '0;
            res_vx_r     <= '0;
            res_vy_r     <= '0;
            res_speed_r  <= '0;
            res_moving_r <= 1'b0;
          end
        end
        ST_AGE_CHK: begin
          if (miss_c > miss_lim_r) begin
            if (idx_c == last_c) begin
              total_r <= total_r - 1'b1;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_AGE_CP: begin
          used_r[idx_c] <= used_r[last_c];
          total_r       <= total_r - 1'b1;
        end
        default: ;
      endcase

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_vx_r     <= res_vx_r;
      out_vy_r     <= res_vy_r;
      out_speed_r  <= res_speed_r;
      out_moving_r <= res_moving_r;
      out_live_r   <= total_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_track_id    = out_id_r;
  assign out_vel_x       = out_vx_r;
  assign out_vel_y       = out_vy_r;
  assign out_speed       = out_speed_r;
  assign out_moving      = out_moving_r;
  assign out_live_tracks = out_live_r;

  `GTA_CHECK(a_total_bound, total_r <= CNT_W'(MAX_TRACKS), "track count above table size")
  `GTA_IMPLY(a_match_found, state_r == ST_MATCH_WR, found_r, "write-back without a match")
  `GTA_IMPLY(a_close_clear, state_r == ST_EMIT && res_status_r == STAT_CLOSED, used_r == '0,
             "used marks survive frame close")
  `GTA_IMPLY(a_drop_full, state_r == ST_EMIT && res_status_r == STAT_DROP,
             total_r == CNT_W'(MAX_TRACKS), "drop with room in table")

endmodule
`default_nettype wire
